// File: src/assert_macros.svh
// Assertion macros shared by the shuffle engine RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold too.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/fys_pkg.sv
// Shared types, constants and helpers for the Fisher-Yates shuffle engine.
// No dependencies; imported by the engine top level.
package fys_pkg;

    // Table geometry
    localparam int TABLE_DEPTH   = 256;
    localparam int ELEMENT_WIDTH = 32;
    localparam int ADDR_W        = $clog2(TABLE_DEPTH);
    localparam int POS_W         = ADDR_W + 1;

    // Beat field widths
    localparam int CMD_W     = 2;
    localparam int DATA_W    = 32;
    localparam int RND_W     = 32;
    localparam int PROD_W    = RND_W + POS_W;
    localparam int CFG_IDX_W = 1;

    // Commands
    localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FILL = 2'd2;
    localparam logic [CMD_W-1:0] CMD_STEP = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LIST_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_LIMIT  = 1'd1;

    // One result beat
    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [ADDR_W-1:0] chosen;
        logic              done;
        logic              err;
    } res_t;

    // Keep an incoming word to the stored element width
    function automatic logic [ELEMENT_WIDTH-1:0] to_elem(input logic [DATA_W-1:0] v);
        logic [ELEMENT_WIDTH+DATA_W-1:0] ext;
        ext = {{ELEMENT_WIDTH{v[DATA_W-1]}}, v};
        return ext[ELEMENT_WIDTH-1:0];
    endfunction

    // Sign-extend a stored element and keep the output width
    function automatic logic [DATA_W-1:0] to_out(input logic [ELEMENT_WIDTH-1:0] v);
        logic [ELEMENT_WIDTH+DATA_W-1:0] ext;
        ext = {{DATA_W{v[ELEMENT_WIDTH-1]}}, v};
        return ext[DATA_W-1:0];
    endfunction

    // Identity value for a fill position, masked to the element width
    function automatic logic [ELEMENT_WIDTH-1:0] fill_word(input logic [POS_W-1:0] k);
        logic [ELEMENT_WIDTH+POS_W-1:0] ext;
        ext = {{ELEMENT_WIDTH{1'b0}}, k};
        return ext[ELEMENT_WIDTH-1:0];
    endfunction

endpackage

// File: src/fys_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; contents are undefined until written.
module fys_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: src/fisher_yates_shuffle_engine.sv
// Fisher-Yates shuffle engine top level: command sequencer around one element RAM.
// Depends on fys_pkg, fys_ram and assert_macros.svh.
//
//  channel  | direction | payload
//  ---------+-----------+-------------------------------------------------------
//  s_axis   | in        | tuser: command; tdata: element_index, element_value,
//           |           |        random_word
//  m_axis   | out       | tdata: read_value, chosen_index; tlast: run_done;
//           |           | tuser: error_flag
//  cfg      | in        | cfg_index, cfg_data (list_length, step_limit)
//
// A step reads entry i, multiplies, reads entry j, then writes i and j back
// through the single write port of the element RAM; the fill writes one entry
// a cycle. One command is in work at a time; s_axis_tready is high while idle.
// A result waiting in the output register does not block the next command;
// the sequencer holds its result until the register is free.
// Reset clears the step position and valid flag and sets limits to 256; table is not cleared.
`include "assert_macros.svh"

module fisher_yates_shuffle_engine
    import fys_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Command beats
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [71:0]          s_axis_tdata,  // [7:0] element_index, [39:8] element_value,
                                                // [71:40] random_word
    input  logic [CMD_W-1:0]     s_axis_tuser,  // [1:0] command
    // Result beats
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [39:0]          m_axis_tdata,  // [31:0] read_value, [39:32] chosen_index
    output logic                 m_axis_tlast,  // run_done
    output logic                 m_axis_tuser,  // [0] error_flag
    // Configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [POS_W-1:0]     cfg_data
);

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_RDJ  = 3'd3;
    localparam logic [2:0] S_SWAP = 3'd4;
    localparam logic [2:0] S_WRJ  = 3'd5;
    localparam logic [2:0] S_FILL = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    // Command beat fields
    logic [ADDR_W-1:0] in_index;
    logic [DATA_W-1:0] in_value;
    logic [RND_W-1:0]  in_rnd;
    logic [CMD_W-1:0]  in_cmd;

    assign in_index = s_axis_tdata[7:0];
    assign in_value = s_axis_tdata[39:8];
    assign in_rnd   = s_axis_tdata[71:40];
    assign in_cmd   = s_axis_tuser;

    // Control and payload registers
    logic [2:0]               state_reg, state_next;
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic [POS_W-1:0]         list_length_reg;
    logic [POS_W-1:0]         step_limit_reg;
    logic [POS_W-1:0]         len_reg, len_next;
    logic [POS_W-1:0]         lim_reg, lim_next;
    logic [RND_W-1:0]         rnd_reg, rnd_next;
    logic [POS_W-1:0]         span_reg, span_next;
    logic [ELEMENT_WIDTH-1:0] vi_reg, vi_next;
    logic [POS_W-1:0]         jofs_reg, jofs_next;
    logic [ADDR_W-1:0]        j_reg, j_next;
    logic [POS_W-1:0]         fill_reg, fill_next;
    res_t                     res_reg, res_next;
    logic                     out_valid_reg, out_valid_next;
    res_t                     out_reg, out_next;

    // RAM port signals
    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_wa;
    logic [ELEMENT_WIDTH-1:0] ram_wd;
    logic                     ram_re;
    logic [ADDR_W-1:0]        ram_ra;
    logic [ELEMENT_WIDTH-1:0] ram_rd;

    // Derived values
    logic             in_fire;
    logic [POS_W-1:0] len_eff;
    logic [POS_W-1:0] lim_eff;
    logic             idx_ok;
    logic             step_ok;
    logic [PROD_W-1:0] product;
    logic [POS_W-1:0] j_sum;

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;

    // Clamp the configured length and limit to their legal ranges
    always_comb
    begin
        if (list_length_reg == '0)
        begin
            len_eff = POS_W'(1);
        end
        else if (list_length_reg > POS_W'(TABLE_DEPTH))
        begin
            len_eff = POS_W'(TABLE_DEPTH);
        end
        else
        begin
            len_eff = list_length_reg;
        end

        if (step_limit_reg == '0)
        begin
            lim_eff = POS_W'(1);
        end
        else if (step_limit_reg > len_eff)
        begin
            lim_eff = len_eff;
        end
        else
        begin
            lim_eff = step_limit_reg;
        end
    end

    assign idx_ok  = {1'b0, in_index} < len_eff;
    assign step_ok = pos_reg < lim_eff;

    // Scale the random word to the remaining span (multiply-high)
    assign product = PROD_W'(rnd_reg) * PROD_W'(span_reg);
    assign j_sum   = pos_reg + jofs_reg;

    // Sequencer next state and RAM port control
    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        len_next       = len_reg;
        lim_next       = lim_reg;
        rnd_next       = rnd_reg;
        span_next      = span_reg;
        vi_next        = vi_reg;
        jofs_next      = jofs_reg;
        j_next         = j_reg;
        fill_next      = fill_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        ram_we         = 1'b0;
        ram_wa         = '0;
        ram_wd         = '0;
        ram_re         = 1'b0;
        ram_ra         = (in_cmd == CMD_READ) ? in_index : pos_reg[ADDR_W-1:0];

        // Drop the result beat once taken
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    len_next = len_eff;
                    lim_next = lim_eff;
                    res_next = '0;
                    case (in_cmd)
                        CMD_LOAD:
                        begin
                            if (idx_ok)
                            begin
                                ram_we         = 1'b1;
                                ram_wa         = in_index;
                                ram_wd         = to_elem(in_value);
                                res_next.value = to_out(to_elem(in_value));
                            end
                            else
                            begin
                                res_next.err = 1'b1;
                            end
                            state_next = S_DONE;
                        end
                        CMD_READ:
                        begin
                            if (idx_ok)
                            begin
                                ram_re     = 1'b1;
                                state_next = S_READ;
                            end
                            else
                            begin
                                res_next.err = 1'b1;
                                state_next   = S_DONE;
                            end
                        end
                        CMD_FILL:
                        begin
                            fill_next  = '0;
                            state_next = S_FILL;
                        end
                        default:
                        begin
                            // Shuffle step: fetch entry i and hold the span
                            if (step_ok)
                            begin
                                ram_re     = 1'b1;
                                rnd_next   = in_rnd;
                                span_next  = len_eff - pos_reg;
                                state_next = S_MUL;
                            end
                            else
                            begin
                                res_next.err = 1'b1;
                                state_next   = S_DONE;
                            end
                        end
                    endcase
                end
            end
            S_READ:
            begin
                res_next.value = to_out(ram_rd);
                state_next     = S_DONE;
            end
            S_MUL:
            begin
                vi_next    = ram_rd;
                jofs_next  = product[PROD_W-1:RND_W];
                state_next = S_RDJ;
            end
            S_RDJ:
            begin
                ram_re     = 1'b1;
                ram_ra     = j_sum[ADDR_W-1:0];
                j_next     = j_sum[ADDR_W-1:0];
                state_next = S_SWAP;
            end
            S_SWAP:
            begin
                // Entry j moves to position i
                ram_we          = 1'b1;
                ram_wa          = pos_reg[ADDR_W-1:0];
                ram_wd          = ram_rd;
                res_next.value  = to_out(ram_rd);
                res_next.chosen = j_reg;
                state_next      = S_WRJ;
            end
            S_WRJ:
            begin
                // Old entry i moves to position j
                ram_we     = 1'b1;
                ram_wa     = j_reg;
                ram_wd     = vi_reg;
                pos_next   = pos_reg + POS_W'(1);
                state_next = S_DONE;
            end
            S_FILL:
            begin
                ram_we = 1'b1;
                ram_wa = fill_reg[ADDR_W-1:0];
                ram_wd = fill_word(fill_reg);
                if (fill_reg == len_reg - POS_W'(1))
                begin
                    pos_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    fill_next = fill_reg + POS_W'(1);
                end
            end
            S_DONE:
            begin
                // Hand the result to the output register when it is free
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_next       = res_reg;
                    out_next.done  = (pos_reg >= lim_reg);
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            pos_reg         <= '0;
            out_valid_reg   <= 1'b0;
            list_length_reg <= POS_W'(TABLE_DEPTH);
            step_limit_reg  <= POS_W'(TABLE_DEPTH);
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_LIST_LENGTH: list_length_reg <= cfg_data;
                    REG_STEP_LIMIT:  step_limit_reg  <= cfg_data;
                    default:         step_limit_reg  <= step_limit_reg;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        len_reg  <= len_next;
        lim_reg  <= lim_next;
        rnd_reg  <= rnd_next;
        span_reg <= span_next;
        vi_reg   <= vi_next;
        jofs_reg <= jofs_next;
        j_reg    <= j_next;
        fill_reg <= fill_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    // Element table
    fys_ram #(
        .WIDTH (ELEMENT_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_wa),
        .wr_data (ram_wd),
        .rd_en   (ram_re),
        .rd_addr (ram_ra),
        .rd_data (ram_rd)
    );

    // Result beat
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.chosen, out_reg.value};
    assign m_axis_tlast  = out_reg.done;
    assign m_axis_tuser  = out_reg.err;

    // Checks
    `ASSERT_IMPLY(a_pos_bounded, 1'b1, pos_reg <= POS_W'(TABLE_DEPTH), "step position overflow")
    `ASSERT_NEXT(a_pos_advance, state_reg == S_WRJ, pos_reg == $past(pos_reg) + POS_W'(1), "step position did not advance")
    `ASSERT_IMPLY(a_j_in_range, state_reg == S_SWAP, (j_reg >= pos_reg[ADDR_W-1:0]) && ({1'b0, j_reg} < len_reg), "partner index out of range")
    `ASSERT_IMPLY(a_fill_bound, state_reg == S_FILL, fill_reg < len_reg, "fill ran past the length")
    `ASSERT_IMPLY(a_err_no_partner, m_axis_tvalid && m_axis_tuser, m_axis_tdata[39:32] == '0, "error beat carries a partner index")

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for fisher_yates_shuffle_engine: directed and random
// command beats, randomized idling on both streams. Depends on fys_pkg and the engine.
module tb_top;
    import fys_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 20;
    localparam int PHASES         = 12;
    localparam int PHASE_ITEMS    = 70;

    // Shadow of the element table, step position and limits; predicts every result beat
    class shuffle_board;
        logic [ELEMENT_WIDTH-1:0] elem_mem [TABLE_DEPTH];
        int unsigned              step_pos;
        logic [POS_W-1:0]         length_reg;
        logic [POS_W-1:0]         limit_reg;
        res_t                     pending_results [$];
        int                       errors;

        function new();
            step_pos   = 0;
            length_reg = POS_W'(256);
            limit_reg  = POS_W'(256);
            errors     = 0;
        endfunction

        function int unsigned eff_length();
            if (length_reg == 0) return 1;
            if (length_reg > TABLE_DEPTH) return TABLE_DEPTH;
            return length_reg;
        endfunction

        function int unsigned eff_limit(int unsigned len);
            if (limit_reg == 0) return 1;
            if (limit_reg > len) return len;
            return limit_reg;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [POS_W-1:0] data);
            if (idx == REG_LIST_LENGTH)
                length_reg = data;
            else
                limit_reg = data;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Apply one accepted command beat and queue the result it must produce
        function void accept_command(logic [CMD_W-1:0] op, logic [7:0] idx,
                                     logic [31:0] val, logic [31:0] rnd);
            int unsigned              len;
            int unsigned              lim;
            int unsigned              j;
            logic [63:0]              prod;
            logic [ELEMENT_WIDTH-1:0] swap_tmp;
            res_t                     r;
            len = eff_length();
            lim = eff_limit(len);
            r   = '0;
            case (op)
                CMD_LOAD:
                begin
                    if (idx < len)
                    begin
                        elem_mem[idx] = val;
                        r.value       = val;
                    end
                    else
                        r.err = 1'b1;
                end
                CMD_READ:
                begin
                    if (idx < len)
                        r.value = elem_mem[idx];
                    else
                        r.err = 1'b1;
                end
                CMD_FILL:
                begin
                    for (int k = 0; k < len; k++)
                        elem_mem[k] = ELEMENT_WIDTH'(k);
                    step_pos = 0;
                end
                default:
                begin
                    if (step_pos < lim)
                    begin
                        // Multiply-high reduction of the random word to the remaining span
                        prod = 64'(rnd) * 64'(len - step_pos);
                        j    = step_pos + int'(prod[63:32]);
                        if (j >= len)
                            j = len - 1;
                        swap_tmp           = elem_mem[step_pos];
                        elem_mem[step_pos] = elem_mem[j];
                        elem_mem[j]        = swap_tmp;
                        r.value            = elem_mem[step_pos];
                        r.chosen           = ADDR_W'(j);
                        step_pos           = step_pos + 1;
                    end
                    else
                        r.err = 1'b1;
                end
            endcase
            r.done = (step_pos >= lim);
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] exp, logic [31:0] got);
            if (exp !== got)
            begin
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp, got);
                errors++;
            end
        endfunction

        // Match one result beat against the oldest prediction
        function void check_result(res_t got);
            res_t exp;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result beat: expected none, actual %0h",
                         $time, got);
                errors++;
                return;
            end
            exp = pending_results.pop_front();
            compare_field("read_value", exp.value, got.value);
            compare_field("chosen_index", 32'(exp.chosen), 32'(got.chosen));
            compare_field("run_done", 32'(exp.done), 32'(got.done));
            compare_field("error_flag", 32'(exp.err), 32'(got.err));
        endfunction
    endclass

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [71:0]          s_axis_tdata  = '0;
    logic [CMD_W-1:0]     s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [39:0]          m_axis_tdata;
    logic                 m_axis_tlast;
    logic                 m_axis_tuser;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [POS_W-1:0]     cfg_data      = '0;

    shuffle_board board;
    int           sender_idle = 0;
    int           recv_stall  = 0;
    int           quiet_cycles = 0;

    fisher_yates_shuffle_engine i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // Stall the result stream at random
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end

    // Check every accepted result beat
    always @(posedge clk)
    begin
        res_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.value  = m_axis_tdata[31:0];
            got.chosen = m_axis_tdata[39:32];
            got.done   = m_axis_tlast;
            got.err    = m_axis_tuser;
            board.check_result(got);
        end
    end

    // Abort when no beat moves on any channel for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Present one command beat after a random gap and hold it until taken
    task automatic send_command(input logic [CMD_W-1:0] op, input logic [7:0] idx,
                                input logic [31:0] val, input logic [31:0] rnd);
        while ($urandom_range(99) < sender_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {rnd, val, idx};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.accept_command(op, idx, val, rnd);
    endtask

    // Drop valid and hold until every predicted result has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending() != 0);
    endtask

    // Write one register; valid stays up so back-to-back writes need no gap
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [POS_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.write_reg(idx, data);
    endtask

    // Bring the engine idle, then load both limits
    task automatic set_limits(input logic [POS_W-1:0] len, input logic [POS_W-1:0] lim);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(REG_LIST_LENGTH, len);
        write_reg(REG_STEP_LIMIT, lim);
        cfg_valid <= 1'b0;
    endtask

    // Pick one command: mostly runs of steps, with reads, loads, refills and noise
    task automatic random_item();
        int unsigned      len;
        int unsigned      lim;
        int unsigned      pick;
        logic [CMD_W-1:0] op;
        logic [7:0]       idx;
        logic [31:0]      val;
        logic [31:0]      rnd;
        len  = board.eff_length();
        lim  = board.eff_limit(len);
        pick = $urandom_range(99);
        if (board.step_pos >= lim)
            op = (pick < 60) ? CMD_FILL : (pick < 75) ? CMD_STEP :
                 (pick < 88) ? CMD_READ : CMD_LOAD;
        else
            op = (pick < 62) ? CMD_STEP : (pick < 78) ? CMD_READ :
                 (pick < 92) ? CMD_LOAD : CMD_FILL;
        if ($urandom_range(9) == 0)
            idx = 8'($urandom_range(255));
        else
            idx = 8'($urandom_range(len - 1));
        case ($urandom_range(15))
            0:       val = 32'h8000_0000;
            1:       val = 32'h7fff_ffff;
            2:       val = 32'hffff_ffff;
            3:       val = 32'h0000_0000;
            default: val = $urandom;
        endcase
        case ($urandom_range(15))
            0:       rnd = 32'h0000_0000;
            1:       rnd = 32'hffff_ffff;
            default: rnd = $urandom;
        endcase
        send_command(op, idx, val, rnd);
    endtask

    initial
    begin
        int          len_set [PHASES];
        int          lim_set [PHASES];
        logic [POS_W-1:0] len_val;
        logic [POS_W-1:0] lim_val;
        len_set = '{256, 1, 0, 511, 2, 2, 16, 40, 300, 7, 256, 0};
        lim_set = '{256, 1, 0, 511, 1, 2, 16, 5, 0, 200, 3, 1};
        board = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Whole table at reset limits: fill first so no entry is left unwritten
        send_command(CMD_FILL, 8'd0, 32'd0, 32'd0);
        send_command(CMD_READ, 8'd0, 32'd0, 32'd0);
        send_command(CMD_READ, 8'd255, 32'd0, 32'd0);
        send_command(CMD_LOAD, 8'd0, 32'h8000_0000, 32'd0);
        send_command(CMD_LOAD, 8'd255, 32'h7fff_ffff, 32'd0);
        send_command(CMD_LOAD, 8'd1, 32'hffff_ffff, 32'hffff_ffff);
        send_command(CMD_READ, 8'd0, 32'd0, 32'd0);
        send_command(CMD_READ, 8'd255, 32'd0, 32'd0);
        send_command(CMD_STEP, 8'd0, 32'd0, 32'h0000_0000);
        send_command(CMD_STEP, 8'd0, 32'd0, 32'hffff_ffff);
        send_command(CMD_STEP, 8'd0, 32'd0, 32'h8000_0000);

        // Short table: index range errors, step past the limit
        set_limits(9'd10, 9'd3);
        send_command(CMD_FILL, 8'd0, 32'd0, 32'd0);
        send_command(CMD_STEP, 8'd0, 32'd0, 32'hffff_ffff);
        send_command(CMD_STEP, 8'd0, 32'd0, 32'h0000_0000);
        send_command(CMD_STEP, 8'd0, 32'd0, 32'h5555_5555);
        send_command(CMD_STEP, 8'd0, 32'd0, 32'h1234_5678);
        send_command(CMD_LOAD, 8'd10, 32'hdead_beef, 32'd0);
        send_command(CMD_READ, 8'd255, 32'd0, 32'd0);
        send_command(CMD_READ, 8'd9, 32'd0, 32'd0);
        send_command(CMD_LOAD, 8'd9, 32'h0000_0001, 32'd0);

        // Limit lowered under a run that already passed it, then raised again
        set_limits(9'd10, 9'd1);
        send_command(CMD_STEP, 8'd0, 32'd0, 32'hffff_ffff);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(REG_STEP_LIMIT, 9'd6);
        cfg_valid <= 1'b0;
        send_command(CMD_STEP, 8'd0, 32'd0, 32'hffff_ffff);
        send_command(CMD_STEP, 8'd0, 32'd0, 32'h0000_0000);

        // Random phases across limit settings and idling patterns
        for (int p = 0; p < PHASES; p++)
        begin
            len_val = (p >= PHASES - 2) ? POS_W'($urandom_range(511)) : POS_W'(len_set[p]);
            lim_val = (p >= PHASES - 2) ? POS_W'($urandom_range(511)) : POS_W'(lim_set[p]);
            set_limits(len_val, lim_val);
            case (p % 4)
                0:
                begin
                    sender_idle = 0;
                    recv_stall  = 0;
                end
                1:
                begin
                    sender_idle = 64;
                    recv_stall  = 0;
                end
                2:
                begin
                    sender_idle = 0;
                    recv_stall  = 64;
                end
                default:
                begin
                    sender_idle = 19;
                    recv_stall  = 19;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(49) == 0)
                    drain_results();
                random_item();
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (board.pending() != 0)
            board.errors++;
        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: sim.f
+incdir+src
src/fys_pkg.sv
src/fys_ram.sv
src/fisher_yates_shuffle_engine.sv
tb/tb_top.sv
